### design/assert_macros.svh
// Assertion helpers for the RTL. Each macro expands to one labeled
// concurrent assertion clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the button click classifier: register
// indexes, reset values, click codes and the structs passed between modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

  localparam int unsigned CfgW  = 16;
  localparam int unsigned TimeW = 32;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_LONG_CLICK   = 2'd0;
  localparam logic [1:0] REG_DOUBLE_CLICK = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE     = 2'd2;

  // Reset values of the registers
  localparam logic [CfgW-1:0] LONG_CLICK_RST   = 16'd500;
  localparam logic [CfgW-1:0] DOUBLE_CLICK_RST = 16'd350;
  localparam logic [CfgW-1:0] DEBOUNCE_RST     = 16'd10;

  // Click event codes
  localparam logic [1:0] EV_SHORT  = 2'd0;
  localparam logic [1:0] EV_DOUBLE = 2'd1;
  localparam logic [1:0] EV_LONG   = 2'd2;

  typedef struct packed {
    logic [CfgW-1:0] long_click_ms;
    logic [CfgW-1:0] double_click_ms;
    logic [CfgW-1:0] debounce_ms;
  } bcc_cfg_t;

  typedef struct packed {
    logic debounced_level;
    logic press_active;
    logic long_reported;
    logic short_pending;
  } bcc_status_t;

endpackage

`default_nettype wire

### design/button_click_classifier.sv
// ----------------------------------------------------------------------------
// button_click_classifier
// Debounces a polled push button and reports short, double and long clicks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one poll per transaction: the
//   raw level pin_high and the millisecond timestamp now_ms.
//   Output channel (out_valid/out_ready) carries click_event: 0 short click,
//   1 double click, 2 long click. A poll yields zero or one event.
//   Timing registers are written through cfg_we/cfg_index/cfg_data while the
//   block is idle, a rule for the user that the block does not enforce:
//   0 long click time, 1 double click window, 2 debounce time.
//   A poll in the input register is evaluated when it advances; its event
//   then enters the result register and is offered from there.
//   Throughput: one poll per cycle unless the result stalls; the input
//   register and the result register form a two-stage path. A stalled result
//   holds in the result register; polls keep flowing until the input register
//   is also full, then in_ready drops. Reset clears the click state, empties
//   both registers and restores the timing registers to 500, 350 and 10 ms.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module button_click_classifier (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [bcc_pkg::CfgW-1:0]  cfg_data,
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic                      pin_high,
  input  wire logic [bcc_pkg::TimeW-1:0] now_ms,
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [1:0]                click_event
);

  bcc_pkg::bcc_cfg_t         cfg;
  bcc_pkg::bcc_status_t      status;
  logic                      stage_valid, stage_pin, advance;
  logic [bcc_pkg::TimeW-1:0] stage_now;
  logic                      ev_valid;
  logic [1:0]                ev_code;
  logic                      load;
  logic                      load_long, load_double, long_latched;

  assign advance = stage_valid && (!out_valid || out_ready);
  assign load    = advance && ev_valid;

  bcc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcc_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pin_high    (pin_high),
    .now_ms      (now_ms),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_pin   (stage_pin),
    .stage_now   (stage_now)
  );

  bcc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .step     (advance),
    .pin      (stage_pin),
    .now      (stage_now),
    .ev_valid (ev_valid),
    .ev_code  (ev_code),
    .status   (status)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      click_event <= ev_code;
    end
  end

  assign load_long    = load && (ev_code == bcc_pkg::EV_LONG);
  assign load_double  = load && (ev_code == bcc_pkg::EV_DOUBLE);
  assign long_latched = status.long_reported && !status.short_pending;

  `ASSERT_NEXT(a_long_sets_flag, load_long, long_latched, "long click flag not set")
  `ASSERT_NEXT(a_double_clears, load_double, !status.short_pending, "short click left pending")
  `ASSERT_IMPL(a_long_in_press, status.long_reported, status.press_active, "stray long flag")
  `ASSERT_NEXT(a_event_shown, load, out_valid && click_event == $past(ev_code), "event lost")

endmodule

`default_nettype wire

### design/bcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// Timing registers of the classifier, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_cfg_regs (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [bcc_pkg::CfgW-1:0] cfg_data,
  output bcc_pkg::bcc_cfg_t            cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_click_ms   <= bcc_pkg::LONG_CLICK_RST;
      cfg.double_click_ms <= bcc_pkg::DOUBLE_CLICK_RST;
      cfg.debounce_ms     <= bcc_pkg::DEBOUNCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcc_pkg::REG_LONG_CLICK:   cfg.long_click_ms   <= cfg_data;
        bcc_pkg::REG_DOUBLE_CLICK: cfg.double_click_ms <= cfg_data;
        bcc_pkg::REG_DEBOUNCE:     cfg.debounce_ms     <= cfg_data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

endmodule

`default_nettype wire

### design/bcc_in_stage.sv
// ----------------------------------------------------------------------------
// bcc_in_stage
// Input register: captures one poll per transaction and holds it until the
// classifier core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_in_stage (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output      logic                     in_ready,
  input  wire logic                     pin_high,
  input  wire logic [bcc_pkg::TimeW-1:0] now_ms,
  input  wire logic                     advance,
  output      logic                     stage_valid,
  output      logic                     stage_pin,
  output      logic [bcc_pkg::TimeW-1:0] stage_now
);

  assign in_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_pin <= pin_high;
      stage_now <= now_ms;
    end
  end

endmodule

`default_nettype wire

### design/bcc_core.sv
// ----------------------------------------------------------------------------
// bcc_core
// Debouncer, press tracker and pending short click timer. One poll is
// evaluated per step; the state updates at the same edge.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire bcc_pkg::bcc_cfg_t        cfg,
  input  wire logic                     step,
  input  wire logic                     pin,
  input  wire logic [bcc_pkg::TimeW-1:0] now,
  output      logic                     ev_valid,
  output      logic [1:0]               ev_code,
  output bcc_pkg::bcc_status_t          status
);

  localparam int unsigned PadW = bcc_pkg::TimeW - bcc_pkg::CfgW;

  logic                      debounced_level, debounced_level_next;
  logic                      settle_active, settle_active_next;
  logic [bcc_pkg::TimeW-1:0] settle_start, settle_start_next;
  logic                      press_active, press_active_next;
  logic [bcc_pkg::TimeW-1:0] press_start, press_start_next;
  logic                      long_reported, long_reported_next;
  logic                      short_pending, short_pending_next;
  logic [bcc_pkg::TimeW-1:0] short_time, short_time_next;

  logic [bcc_pkg::TimeW-1:0] settle_age, press_age, short_age;
  logic                      settle_done, long_reached, in_window, short_recorded;

  assign settle_age   = now - settle_start;
  assign press_age    = now - press_start;
  assign short_age    = now - short_time;
  assign settle_done  = settle_age > {{PadW{1'b0}}, cfg.debounce_ms};
  assign long_reached = press_age >= {{PadW{1'b0}}, cfg.long_click_ms};
  assign in_window    = short_age < {{PadW{1'b0}}, cfg.double_click_ms};

  always_comb begin
    debounced_level_next = debounced_level;
    settle_active_next   = settle_active;
    settle_start_next    = settle_start;
    press_active_next    = press_active;
    press_start_next     = press_start;
    long_reported_next   = long_reported;
    short_pending_next   = short_pending;
    short_time_next      = short_time;
    short_recorded       = 1'b0;
    ev_valid             = 1'b0;
    ev_code              = bcc_pkg::EV_SHORT;

    // debouncer: start the settle timer on a change, adopt raw once expired
    if (!settle_active) begin
      if (pin != debounced_level) begin
        settle_active_next = 1'b1;
        settle_start_next  = now;
      end
    end else if (settle_done) begin
      debounced_level_next = pin;
      settle_active_next   = 1'b0;
    end

    // press tracker
    if (!press_active) begin
      if (debounced_level_next) begin
        press_active_next = 1'b1;
        press_start_next  = now;
      end
    end else if (debounced_level_next) begin
      if (!long_reported && long_reached) begin
        ev_valid           = 1'b1;
        ev_code            = bcc_pkg::EV_LONG;
        short_pending_next = 1'b0;
        long_reported_next = 1'b1;
      end
    end else begin
      if (!long_reached) begin
        if (!short_pending) begin
          short_pending_next = 1'b1;
          short_time_next    = now;
          short_recorded     = 1'b1;
        end else if (in_window) begin
          ev_valid           = 1'b1;
          ev_code            = bcc_pkg::EV_DOUBLE;
          short_pending_next = 1'b0;
        end
      end
      press_active_next  = 1'b0;
      long_reported_next = 1'b0;
    end

    // report a pending short click once the window has run out; a click
    // recorded on this poll has age zero
    if (!debounced_level_next && short_pending_next &&
        (short_recorded ? (cfg.double_click_ms == '0) : !in_window)) begin
      ev_valid           = 1'b1;
      ev_code            = bcc_pkg::EV_SHORT;
      short_pending_next = 1'b0;
    end

    if (!step) begin
      ev_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounced_level <= 1'b0;
      settle_active   <= 1'b0;
      settle_start    <= '0;
      press_active    <= 1'b0;
      press_start     <= '0;
      long_reported   <= 1'b0;
      short_pending   <= 1'b0;
      short_time      <= '0;
    end else if (step) begin
      debounced_level <= debounced_level_next;
      settle_active   <= settle_active_next;
      settle_start    <= settle_start_next;
      press_active    <= press_active_next;
      press_start     <= press_start_next;
      long_reported   <= long_reported_next;
      short_pending   <= short_pending_next;
      short_time      <= short_time_next;
    end
  end

  assign status.debounced_level = debounced_level;
  assign status.press_active    = press_active;
  assign status.long_reported   = long_reported;
  assign status.short_pending   = short_pending;

endmodule

`default_nettype wire

### bench/tb_button_click_classifier.sv
// ----------------------------------------------------------------------------
// tb_button_click_classifier
// Self-checking bench for the button click classifier. A queue of polls feeds
// a valid/ready driver. Every accepted poll runs through a local model of the
// debouncer, press tracker and short click timer. A monitor compares each
// click event with the oldest predicted one. Timing registers are changed
// between phases, and the bench varies idle and stall rates on both channels.
// ----------------------------------------------------------------------------
module tb_button_click_classifier;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE = 2'd3;   // no register behind this index
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_POLLS  = 320;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_AT      = 850;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic        pin;
    logic [31:0] ts;
  } poll_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [1:0]                cfg_index = bcc_pkg::REG_LONG_CLICK;
  logic [bcc_pkg::CfgW-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      pin_high = 1'b0;
  logic [bcc_pkg::TimeW-1:0] now_ms = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [1:0]                click_event;

  button_click_classifier dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pin_high    (pin_high),
    .now_ms      (now_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .click_event (click_event)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Timing copy and click state of the local model
  logic [15:0] long_ms  = bcc_pkg::LONG_CLICK_RST;
  logic [15:0] dbl_ms   = bcc_pkg::DOUBLE_CLICK_RST;
  logic [15:0] settle_ms = bcc_pkg::DEBOUNCE_RST;

  logic        db_level      = 1'b0;
  logic        prev_level    = 1'b0;
  logic        settling      = 1'b0;
  logic [31:0] settle_t0     = '0;
  logic        pressed       = 1'b0;
  logic [31:0] press_t0      = '0;
  logic        long_sent     = 1'b0;
  logic        short_waiting = 1'b0;
  logic [31:0] short_t0      = '0;

  poll_t       polls_todo[$];
  logic [1:0]  clicks_due[$];
  logic [31:0] stim_ts = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned polls_in = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned err_cnt = 0;
  int unsigned n_short = 0, n_double = 0, n_long = 0;
  int unsigned n_settings = 0;
  int unsigned cycle_cnt = 0;

  // Advance the model by one poll; returns 1 when the poll yields a click.
  function automatic bit classify_poll(input logic pin, input logic [31:0] ts,
                                       output logic [1:0] ev);
    logic [31:0] dt_settle, dt_press, dt_short;
    bit hit;
    hit = 1'b0;
    ev = bcc_pkg::EV_SHORT;
    dt_settle = ts - settle_t0;
    if (!settling) begin
      if (pin != prev_level) begin
        settling = 1'b1;
        settle_t0 = ts;
      end
    end else if (dt_settle > {16'd0, settle_ms}) begin
      db_level = pin;
      settling = 1'b0;
    end

    dt_press = ts - press_t0;
    if (!pressed) begin
      if (db_level) begin
        pressed = 1'b1;
        press_t0 = ts;
      end
    end else if (db_level) begin
      if (!long_sent && dt_press >= {16'd0, long_ms}) begin
        ev = bcc_pkg::EV_LONG;
        hit = 1'b1;
        short_waiting = 1'b0;
        long_sent = 1'b1;
      end
    end else begin
      if (dt_press < {16'd0, long_ms}) begin
        dt_short = ts - short_t0;
        if (!short_waiting) begin
          short_waiting = 1'b1;
          short_t0 = ts;
        end else if (dt_short < {16'd0, dbl_ms}) begin
          ev = bcc_pkg::EV_DOUBLE;
          hit = 1'b1;
          short_waiting = 1'b0;
        end
      end
      pressed = 1'b0;
      long_sent = 1'b0;
    end

    // pending short click times out while released
    dt_short = ts - short_t0;
    if (!db_level && short_waiting && dt_short >= {16'd0, dbl_ms}) begin
      ev = bcc_pkg::EV_SHORT;
      hit = 1'b1;
      short_waiting = 1'b0;
    end

    prev_level = db_level;
    return hit;
  endfunction

  // Input side: hold a poll until accepted, then advance
  always @(posedge clk) begin : drive
    poll_t      nxt;
    logic [1:0] ev;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (classify_poll(pin_high, now_ms, ev)) clicks_due.push_back(ev);
        polls_in <= polls_in + 1;
      end
      if (!in_valid || in_ready) begin
        if (polls_todo.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = polls_todo.pop_front();
          pin_high <= nxt.pin;
          now_ms   <= nxt.ts;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side: check each click transaction, stall at random or for a long hold
  always @(posedge clk) begin : watch
    logic [1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (clicks_due.size() == 0) begin
          $error("click_event: expected none, actual %0d", click_event);
          err_cnt++;
        end else begin
          want = clicks_due.pop_front();
          if (click_event !== want) begin
            $error("click_event: expected %0d, actual %0d", want, click_event);
            err_cnt++;
          end
          case (want)
            bcc_pkg::EV_SHORT:  n_short++;
            bcc_pkg::EV_DOUBLE: n_double++;
            default:            n_long++;
          endcase
        end
      end
      if (!hold_done && polls_in >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_button_click_classifier: done, errors");
    $finish;
  end

  task automatic queue_at(input logic pin, input logic [31:0] ts);
    poll_t p;
    p.pin = pin;
    p.ts = ts;
    stim_ts = ts;
    polls_todo.push_back(p);
  endtask

  task automatic queue_poll(input logic pin, input logic [31:0] dt);
    queue_at(pin, stim_ts + dt);
  endtask

  // A span near a threshold: inside, right at it, just past or well past
  function automatic int unsigned pick_span(input int unsigned lim);
    case ($urandom_range(3))
      0:       return $urandom_range(lim);
      1:       return lim + $urandom_range(2);
      2:       return (lim > 2) ? lim - $urandom_range(2, 1) : lim;
      default: return lim + $urandom_range(lim + 20);
    endcase
  endfunction

  // One press and release with random polling, or a burst of noise
  task automatic queue_gesture();
    int unsigned hold, gap, stepmax, elapsed, dt;
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(6, 1)) begin
        dt = ($urandom_range(9) == 0) ? $urandom : $urandom_range(settle_ms + 2);
        queue_poll(1'($urandom_range(1)), dt);
      end
    end else begin
      hold = pick_span(long_ms) + settle_ms;
      gap  = pick_span(dbl_ms) + settle_ms;
      if ($urandom_range(3) == 0) begin
        // contact bounce
        repeat ($urandom_range(3, 1)) begin
          queue_poll(1'b1, $urandom_range(settle_ms / 2));
          queue_poll(1'b0, $urandom_range(settle_ms / 2));
        end
      end
      stepmax = hold / 4 + 1;
      elapsed = 0;
      do begin
        dt = ($urandom_range(15) == 0) ? 0 : $urandom_range(stepmax, 1);
        queue_poll(1'b1, dt);
        elapsed += dt;
      end while (elapsed <= hold);
      stepmax = gap / 4 + 1;
      elapsed = 0;
      do begin
        dt = ($urandom_range(15) == 0) ? 0 : $urandom_range(stepmax, 1);
        queue_poll(1'b0, dt);
        elapsed += dt;
      end while (elapsed <= gap);
    end
  endtask

  // Let every poll and click drain, plus the pipeline tail
  task automatic wait_idle();
    while (polls_todo.size() != 0 || in_valid || clicks_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_timing(input logic [15:0] lc, input logic [15:0] dc,
                            input logic [15:0] db);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= bcc_pkg::REG_LONG_CLICK;
    cfg_data  <= lc;
    @(posedge clk);
    cfg_index <= bcc_pkg::REG_DOUBLE_CLICK;
    cfg_data  <= dc;
    @(posedge clk);
    cfg_index <= bcc_pkg::REG_DEBOUNCE;
    cfg_data  <= db;
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_data  <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    long_ms   = lc;
    dbl_ms    = dc;
    settle_ms = db;
    n_settings++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned goal;
    logic [15:0] lc, dc, db;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset timing, zero timestamp, double, long, late second release, wrap
    queue_at(1'b1, 32'd0);
    queue_at(1'b1, 32'd5);
    queue_at(1'b1, 32'd11);
    queue_at(1'b0, 32'd20);
    queue_at(1'b0, 32'd31);
    queue_at(1'b1, 32'd40);
    queue_at(1'b1, 32'd51);
    queue_at(1'b0, 32'd60);
    queue_at(1'b0, 32'd71);
    queue_at(1'b1, 32'd100);
    queue_at(1'b1, 32'd111);
    queue_at(1'b1, 32'd700);
    queue_at(1'b1, 32'd800);
    queue_at(1'b0, 32'd810);
    queue_at(1'b0, 32'd821);
    queue_at(1'b1, 32'd830);
    queue_at(1'b1, 32'd841);
    queue_at(1'b0, 32'd850);
    queue_at(1'b0, 32'd861);
    queue_at(1'b1, 32'd862);
    queue_at(1'b1, 32'd874);
    queue_at(1'b0, 32'd1250);
    queue_at(1'b0, 32'd1262);
    queue_at(1'b1, 32'hFFFF_FFFF);
    queue_at(1'b1, 32'h0000_0010);
    queue_at(1'b0, 32'h8000_0000);
    queue_at(1'b0, 32'hFFFF_FFFE);

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          lc = bcc_pkg::LONG_CLICK_RST;
          dc = bcc_pkg::DOUBLE_CLICK_RST;
          db = bcc_pkg::DEBOUNCE_RST;
        end
        1: begin lc = 16'd40; dc = 16'd25; db = 16'd3; end
        2: begin lc = 16'd0; dc = 16'd0; db = 16'd0; end
        3: begin lc = 16'hFFFF; dc = 16'hFFFF; db = 16'hFFFF; end
        4: begin lc = 16'd200; dc = 16'd0; db = 16'd1; end
        default: begin
          lc = 16'($urandom_range(600, 1));
          dc = 16'($urandom_range(400));
          db = 16'($urandom_range(20));
        end
      endcase
      set_timing(lc, dc, db);
      case (ph % 3)
        0: begin tx_idle_pct = 22; rx_idle_pct = 82; end
        1: begin tx_idle_pct = 82; rx_idle_pct = 22; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      // start some phases just below the wrap point
      stim_ts = ($urandom_range(1) == 0) ? $urandom : 32'hFFFF_FFFF - $urandom_range(200000);
      goal = polls_todo.size() + PHASE_POLLS;
      while (polls_todo.size() < goal) queue_gesture();
    end
    wait_idle();

    $display("Covered %0d polls over %0d timing settings, with a long output stall",
             polls_in, n_settings);
    $display("Clicks checked: %0d short, %0d double, %0d long", n_short, n_double, n_long);
    if (err_cnt == 0) begin
      $display("tb_button_click_classifier: done, clean");
    end else begin
      $display("tb_button_click_classifier: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/bcc_pkg.sv
design/bcc_cfg_regs.sv
design/bcc_in_stage.sv
design/bcc_core.sv
design/button_click_classifier.sv
bench/tb_button_click_classifier.sv
